// ----- rtl/core/ifnb_pkg.sv -----
// ----------------------------------------------------------------------------
// ifnb_pkg
// Shared widths, reset values, register indexes and result types of the
// in-place four-neighbour blur unit.
// ----------------------------------------------------------------------------
`default_nettype none

package ifnb_pkg;

    localparam int PIX_W         = 24;
    localparam int CH_W          = 8;
    localparam int NUM_CH        = PIX_W / CH_W;
    localparam int WIDTH_W       = 11;
    localparam int HEIGHT_W      = 12;
    localparam int CFG_DATA_W    = 12;
    localparam int CFG_IDX_W     = 1;
    localparam int RES_MAX       = 3;
    localparam int RES_CNT_W     = 2;
    localparam int MAX_WIDTH_DEF = 1024;

    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(640);
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(480);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } t_reg_index;

    // One output word with its side flags.
    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             last_of_run;
        logic             end_of_frame;
    } t_result;

    // All words caused by one input word, lowest index delivered first.
    typedef struct packed {
        logic [RES_CNT_W-1:0]      count;
        t_result [RES_MAX-1:0]     res;
    } t_batch;

endpackage

`default_nettype wire

// ----- rtl/core/ifnb_row_ram.sv -----
// ----------------------------------------------------------------------------
// ifnb_row_ram
// One-row line memory: one write port, one read port with registered data.
// A read of the address written in the same cycle returns the new data.
// ----------------------------------------------------------------------------
`default_nettype none

module ifnb_row_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 24
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            if (i_we && (i_waddr == i_raddr)) begin
                r_rdata <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_raddr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- rtl/core/ifnb_result_buf.sv -----
// ----------------------------------------------------------------------------
// ifnb_result_buf
// Output register for up to three result words of one input word.
// Words leave one per cycle from entry zero while i_ready is high; the rest shift down.
// ----------------------------------------------------------------------------
`default_nettype none

module ifnb_result_buf import ifnb_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_load,
    input  wire t_batch  i_batch,
    output logic         o_space,
    output logic         o_valid,
    input  wire logic    i_ready,
    output t_result      o_result
);

    t_result [RES_MAX-1:0] r_res;
    t_result [RES_MAX-1:0] n_res;
    logic [RES_CNT_W-1:0]  r_cnt;
    logic [RES_CNT_W-1:0]  n_cnt;
    logic                  take;

    assign take    = (r_cnt != '0) && i_ready;
    assign o_space = (r_cnt == '0) || (take && (r_cnt == RES_CNT_W'(1)));

    always_comb begin
        n_res = r_res;
        n_cnt = r_cnt;
        if (i_load) begin
            n_res = i_batch.res;
            n_cnt = i_batch.count;
        end else if (take) begin
            for (int i = 0; i < RES_MAX - 1; i++) begin
                n_res[i] = r_res[i + 1];
            end
            n_cnt = r_cnt - RES_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_valid  = (r_cnt != '0);
    assign o_result = r_res[0];

`ifndef SYNTHESIS
    a_load_needs_space: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_space)
        else $error("result buffer loaded while still holding words");

    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && !o_result.last_of_run) |=> o_valid)
        else $error("run of result words broke off before its last word");

    a_eof_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.end_of_frame) |-> o_result.last_of_run)
        else $error("end of frame word is not the last of its run");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/inplace_four_neighbour_blur_unit.sv -----
// ----------------------------------------------------------------------------
// inplace_four_neighbour_blur_unit
// Streaming in-place cross blur of 24-bit RGB frames in raster order.
// ----------------------------------------------------------------------------
// Usage: pixels of a frame enter on the input channel (i_in_valid, o_in_ready,
// i_pixel_in), one word per ready cycle, in raster order. Blurred pixels leave on the
// output channel (o_out_valid, i_out_ready, o_pixel_out) one row behind. Row r
// is delivered while row r+1 enters; the bottom row is delivered interleaved
// with the row above it, so a bottom-row input word causes two words, the one
// in the first column only one and the bottom-right one three. o_last_of_run
// marks the last word of each run, o_end_of_frame the bottom-right pixel.
// An accepted word is registered in the stage register, and its results are
// loaded into the output register when it leaves that stage. Words are taken
// one per cycle while the receiver keeps up, in all rows but the bottom one,
// where the single output port sets the pace: a bottom-row word causes two
// results, three at the bottom-right pixel.
// A stalled receiver holds the output register; the stage register keeps one
// more word and only then is o_in_ready dropped. Reset sets the frame size to
// 640 by 480 and the position to the top-left; the line memories need no
// clearing. A configuration write also restarts the frame at the top-left.
`default_nettype none

module inplace_four_neighbour_blur_unit import ifnb_pkg::*; #(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic [PIX_W-1:0]      i_pixel_in,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic      [PIX_W-1:0]      o_pixel_out,
    output logic                       o_last_of_run,
    output logic                       o_end_of_frame,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    // Column address width, and a width wide enough for both the register and
    // the largest row length, used to clamp the programmed width.
    localparam int AW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int EW  = (WW > WIDTH_W) ? WW : WIDTH_W;

    // Per channel floor of the sum of four neighbours over four.
    function automatic logic [PIX_W-1:0] avg4(
        input logic [PIX_W-1:0] a,
        input logic [PIX_W-1:0] b,
        input logic [PIX_W-1:0] c,
        input logic [PIX_W-1:0] d
    );
        logic [PIX_W-1:0] res;
        logic [CH_W+1:0]  sum;
        res = '0;
        for (int ch = 0; ch < NUM_CH; ch++) begin
            sum = (CH_W+2)'(a[ch*CH_W +: CH_W]) + (CH_W+2)'(b[ch*CH_W +: CH_W])
                + (CH_W+2)'(c[ch*CH_W +: CH_W]) + (CH_W+2)'(d[ch*CH_W +: CH_W]);
            res[ch*CH_W +: CH_W] = sum[CH_W+1:2];
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers and the effective frame size.
    // ------------------------------------------------------------------
    logic [WIDTH_W-1:0]  r_width;
    logic [HEIGHT_W-1:0] r_height;
    logic [EW-1:0]       w_ext;
    logic [EW-1:0]       w_eff;
    logic [AW-1:0]       last_col;
    logic [HEIGHT_W-1:0] h_eff;
    logic [HEIGHT_W-1:0] last_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
        end else if (i_cfg_we) begin
            case (t_reg_index'(i_cfg_index))
                REG_WIDTH:  r_width  <= i_cfg_data[WIDTH_W-1:0];
                REG_HEIGHT: r_height <= i_cfg_data[HEIGHT_W-1:0];
                default:    ;
            endcase
        end
    end

    // A width below two counts as two, one above the line memory as its size.
    assign w_ext    = EW'(r_width);
    assign w_eff    = (w_ext < EW'(2)) ? EW'(2)
                    : ((w_ext > EW'(MAX_WIDTH)) ? EW'(MAX_WIDTH) : w_ext);
    assign last_col = AW'(w_eff - EW'(1));
    assign h_eff    = (r_height < HEIGHT_W'(2)) ? HEIGHT_W'(2) : r_height;
    assign last_row = h_eff - HEIGHT_W'(1);

    // ------------------------------------------------------------------
    // Position of the next input word. Every register write restarts the
    // frame, so the position always lies inside the programmed frame.
    // ------------------------------------------------------------------
    logic [AW-1:0]       r_col;
    logic [AW-1:0]       n_col;
    logic [HEIGHT_W-1:0] r_row;
    logic [HEIGHT_W-1:0] n_row;
    logic                in_accept;

    assign in_accept = i_in_valid && o_in_ready;

    always_comb begin
        n_col = r_col + AW'(1);
        n_row = r_row;
        if (r_col == last_col) begin
            n_col = '0;
            n_row = (r_row == last_row) ? '0 : r_row + HEIGHT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_cfg_we) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // ------------------------------------------------------------------
    // Stage register: the accepted word with its position flags. The line
    // memories are read on the accepting edge, so their data lines up with
    // this stage.
    // ------------------------------------------------------------------
    logic             r_s1_valid;
    logic [PIX_W-1:0] r_s1_pix;
    logic [AW-1:0]    r_s1_col;
    logic             r_s1_first_col;
    logic             r_s1_second_col;
    logic             r_s1_last_col;
    logic             r_s1_row0;
    logic             r_s1_row1;
    logic             r_s1_last_row;
    logic             s1_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_pix        <= i_pixel_in;
            r_s1_col        <= r_col;
            r_s1_first_col  <= (r_col == '0);
            r_s1_second_col <= (r_col == AW'(1));
            r_s1_last_col   <= (r_col == last_col);
            r_s1_row0       <= (r_row == '0);
            r_s1_row1       <= (r_row == HEIGHT_W'(1));
            r_s1_last_row   <= (r_row == last_row);
        end
    end

    // ------------------------------------------------------------------
    // Line memories. The original row is kept twice so that the pixel's own
    // column and the column to its right are read in the same cycle. Each
    // stage word writes its column when it leaves the stage; blur memory skips row 0.
    // ------------------------------------------------------------------
    logic [PIX_W-1:0] own_orig;
    logic [PIX_W-1:0] right_orig;
    logic [PIX_W-1:0] up_blur;
    logic [PIX_W-1:0] blur_b;

    ifnb_row_ram #(.DEPTH(MAX_WIDTH), .AW(AW), .DW(PIX_W)) u_orig_own (
        .i_clk   (i_clk),
        .i_we    (s1_fire),
        .i_waddr (r_s1_col),
        .i_wdata (r_s1_pix),
        .i_re    (in_accept),
        .i_raddr (r_col),
        .o_rdata (own_orig)
    );

    ifnb_row_ram #(.DEPTH(MAX_WIDTH), .AW(AW), .DW(PIX_W)) u_orig_right (
        .i_clk   (i_clk),
        .i_we    (s1_fire),
        .i_waddr (r_s1_col),
        .i_wdata (r_s1_pix),
        .i_re    (in_accept),
        .i_raddr (r_col + AW'(1)),
        .o_rdata (right_orig)
    );

    ifnb_row_ram #(.DEPTH(MAX_WIDTH), .AW(AW), .DW(PIX_W)) u_blur_up (
        .i_clk   (i_clk),
        .i_we    (s1_fire && !r_s1_row0),
        .i_waddr (r_s1_col),
        .i_wdata (blur_b),
        .i_re    (in_accept),
        .i_raddr (r_col),
        .o_rdata (up_blur)
    );

    // ------------------------------------------------------------------
    // Blur arithmetic. The left blurred neighbour is always the previous
    // word's result of the same row, and in the bottom row the previous
    // original pixel and the last bottom-row result come from registers.
    // ------------------------------------------------------------------
    logic [PIX_W-1:0] r_prev_b;
    logic [PIX_W-1:0] r_prev_p;
    logic [PIX_W-1:0] r_left_blur;
    logic [PIX_W-1:0] left_n;
    logic [PIX_W-1:0] right_n;
    logic [PIX_W-1:0] up_n;
    logic [PIX_W-1:0] left2_n;
    logic [PIX_W-1:0] blur_b2;
    logic [PIX_W-1:0] blur_b3;
    t_batch           batch;
    logic             buf_space;

    // Neighbours outside the image take the pixel's own original value.
    assign left_n  = r_s1_first_col ? own_orig : r_prev_b;
    assign right_n = r_s1_last_col  ? own_orig : right_orig;
    assign up_n    = r_s1_row1      ? own_orig : up_blur;
    assign blur_b  = avg4(left_n, right_n, up_n, r_s1_pix);

    // Bottom-row pixel one column to the left; nothing lies below it.
    assign left2_n = r_s1_second_col ? r_prev_p : r_left_blur;
    assign blur_b2 = avg4(left2_n, r_s1_pix, r_prev_b, r_prev_p);

    // Bottom-right pixel, finished once its left neighbour is known.
    assign blur_b3 = avg4(blur_b2, r_s1_pix, blur_b, r_s1_pix);

    always_comb begin
        batch = '0;
        batch.res[0].pixel = blur_b;
        batch.res[1].pixel = blur_b2;
        batch.res[2].pixel = blur_b3;
        if (r_s1_row0) begin
            batch.count = '0;
        end else if (!r_s1_last_row || r_s1_first_col) begin
            batch.count              = RES_CNT_W'(1);
            batch.res[0].last_of_run = 1'b1;
        end else if (!r_s1_last_col) begin
            batch.count              = RES_CNT_W'(2);
            batch.res[1].last_of_run = 1'b1;
        end else begin
            batch.count               = RES_CNT_W'(3);
            batch.res[2].last_of_run  = 1'b1;
            batch.res[2].end_of_frame = 1'b1;
        end
    end

    // A word that causes no result leaves the stage without waiting.
    assign s1_fire    = r_s1_valid && ((batch.count == '0) || buf_space);
    assign o_in_ready = !r_s1_valid || s1_fire;

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_prev_b <= blur_b;
            r_prev_p <= r_s1_pix;
            if (r_s1_last_row && !r_s1_first_col) begin
                r_left_blur <= blur_b2;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register.
    // ------------------------------------------------------------------
    t_result out_res;

    ifnb_result_buf u_result_buf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (s1_fire && (batch.count != '0)),
        .i_batch  (batch),
        .o_space  (buf_space),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_result (out_res)
    );

    assign o_pixel_out    = out_res.pixel;
    assign o_last_of_run  = out_res.last_of_run;
    assign o_end_of_frame = out_res.end_of_frame;

`ifndef SYNTHESIS
    a_pos_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_col <= last_col) && (r_row <= last_row))
        else $error("input position lies outside the programmed frame");

    a_accept_fills_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> r_s1_valid)
        else $error("accepted word did not reach the stage register");

    a_bottom_right_three: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && r_s1_last_row && r_s1_last_col && !r_s1_row0)
            |=> (o_out_valid && !o_last_of_run))
        else $error("bottom-right word did not start a run of three results");
`endif

endmodule

`default_nettype wire
